// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the design files. Synthesis builds
// define SYNTH, which leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The expression must never be true at a clock edge outside reset.
`define AST_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");

`else

`define AST_NEVER(label, clk, rst_n, expr)
`define AST_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/cceg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cceg_pkg
// Types, constants and register codes shared by the crank/cam event
// generator modules.
// ----------------------------------------------------------------------------
package cceg_pkg;

	// Default sizing of the crank wheel and engine cycle.
	localparam int DEF_MAX_POSITIONS_PER_TURN = 64;
	localparam int DEF_TURNS_PER_CYCLE        = 2;

	// Descriptor queue depth between classifier and event sequencer.
	localparam int QUEUE_DEPTH = 2;

	// Fixed field widths.
	localparam int PERIOD_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int PPT_W      = 7;
	localparam int ABSENT_W   = 6;
	localparam int CAM_EDGE_W = 9;
	localparam int MIN_HOLD_W = 8;
	localparam int EVT_CNT_W  = 3;

	// One item causes at most six events; the event index stays below this.
	localparam logic [EVT_CNT_W-1:0] EVT_IDX_LIMIT = 3'd6;

	// Register reset values.
	localparam logic [PPT_W-1:0]      RST_POSITIONS_PER_TURN = 7'd60;
	localparam logic [ABSENT_W-1:0]   RST_ABSENT_POSITIONS   = 6'd2;
	localparam logic [CAM_EDGE_W-1:0] RST_CAM_HIGH_START     = 9'd10;
	localparam logic [CAM_EDGE_W-1:0] RST_CAM_HIGH_END       = 9'd40;
	localparam logic [MIN_HOLD_W-1:0] RST_MIN_HOLD_CYCLES    = 8'd3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POSITIONS_PER_TURN = 3'd0,
		REG_ABSENT_POSITIONS   = 3'd1,
		REG_CAM_HIGH_START     = 3'd2,
		REG_CAM_HIGH_END       = 3'd3,
		REG_MIN_HOLD_CYCLES    = 3'd4
	} cceg_reg_t;

	// Cam ranges within the engine cycle.
	localparam logic [1:0] SEG_LOW_FIRST = 2'd0;
	localparam logic [1:0] SEG_HIGH      = 2'd1;
	localparam logic [1:0] SEG_DONE      = 2'd3;

	// Event channels.
	localparam logic CH_CRANK = 1'b0;
	localparam logic CH_CAM   = 1'b1;

	// Classified item: everything the sequencer needs to emit its events.
	typedef struct packed {
		logic                tooth;      // present tooth: high then low event
		logic [PERIOD_W-1:0] period;
		logic                gap_emit;   // turn ends: gap low event
		logic [PERIOD_W-1:0] gap_val;
		logic [1:0]          cam_seg;    // first cam range closed by this item
		logic [1:0]          cam_n0;     // ranges closed before the period adds in
		logic [1:0]          cam_n;      // all ranges closed by this item
		logic [PERIOD_W-1:0] cam_sum0;   // accumulated sum before this item
		logic [PERIOD_W-1:0] cam_sum1;   // sum after this item's period adds in
	} cceg_desc_t;

	// One emitted event.
	typedef struct packed {
		logic                underflow;
		logic                level;
		logic                channel;
		logic [PERIOD_W-1:0] hold;
		logic                last;
	} cceg_event_t;

	// Queue status.
	typedef struct packed {
		logic full;
		logic empty;
	} cceg_qstat_t;

	// Sequencer status.
	typedef struct packed {
		logic                 active;
		logic [EVT_CNT_W-1:0] idx;
	} cceg_bstat_t;

endpackage

// File: design/cceg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cceg_front
// Configuration registers and item classifier. Tracks the position in the
// turn and in the engine cycle, accumulates gap and cam sums, and pushes one
// descriptor per accepted item.
// ----------------------------------------------------------------------------
module cceg_front import cceg_pkg::*; #(
	parameter int MAX_POSITIONS_PER_TURN = DEF_MAX_POSITIONS_PER_TURN,
	parameter int TURNS_PER_CYCLE        = DEF_TURNS_PER_CYCLE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PERIOD_W-1:0]   s_axis_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_full,
	output logic                  push,
	output cceg_desc_t            push_desc,
	output logic [MIN_HOLD_W-1:0] min_hold
);

	localparam int TOT_MAX = MAX_POSITIONS_PER_TURN * TURNS_PER_CYCLE;
	localparam int TP_W    = $clog2(MAX_POSITIONS_PER_TURN);
	localparam int CP_W    = $clog2(TOT_MAX);
	localparam int CMP_W   = ($clog2(TOT_MAX + 1) > CAM_EDGE_W) ?
		$clog2(TOT_MAX + 1) : CAM_EDGE_W;
	localparam logic [CMP_W-1:0] MAX_C   = CMP_W'(MAX_POSITIONS_PER_TURN);
	localparam logic [CMP_W-1:0] TURNS_C = CMP_W'(TURNS_PER_CYCLE);

	logic [PPT_W-1:0]      ppt_q;
	logic [ABSENT_W-1:0]   absent_q;
	logic [CAM_EDGE_W-1:0] start_q;
	logic [CAM_EDGE_W-1:0] end_q;
	logic [MIN_HOLD_W-1:0] min_hold_q;

	logic [TP_W-1:0]     tp_q;
	logic [CP_W-1:0]     cp_q;
	logic [PERIOD_W-1:0] gap_sum_q;
	logic [PERIOD_W-1:0] cam_sum_q;
	logic [1:0]          seg_q;

	logic [CMP_W-1:0] ppt_ext, plen, absent_ext, present, total;
	logic [CMP_W-1:0] start_ext, end_ext, rise, fall, tp_ext, tp_inc, cp_ext;
	logic             tooth, turn_end, cycle_done;
	logic [PERIOD_W-1:0] d, gap_acc, sum_mid, sum1;
	logic [1:0]       n0, n_all, seg_end;

	// Number of cam ranges, starting at seg, whose end lies at or below c.
	function automatic logic [1:0] count_closed(
		input logic [1:0]       seg,
		input logic [CMP_W-1:0] e0,
		input logic [CMP_W-1:0] e1,
		input logic [CMP_W-1:0] e2,
		input logic [CMP_W-1:0] c
	);
		logic a0, a1, a2;
		a0 = (seg == SEG_LOW_FIRST) && (e0 <= c);
		a1 = (seg <= SEG_HIGH) && (e1 <= c);
		a2 = (e2 <= c);
		return {1'b0, a0} + {1'b0, a1} + {1'b0, a2};
	endfunction

	// Configuration writes; indexes beyond the list are ignored.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppt_q      <= RST_POSITIONS_PER_TURN;
			absent_q   <= RST_ABSENT_POSITIONS;
			start_q    <= RST_CAM_HIGH_START;
			end_q      <= RST_CAM_HIGH_END;
			min_hold_q <= RST_MIN_HOLD_CYCLES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POSITIONS_PER_TURN: ppt_q      <= cfg_data[PPT_W-1:0];
				REG_ABSENT_POSITIONS:   absent_q   <= cfg_data[ABSENT_W-1:0];
				REG_CAM_HIGH_START:     start_q    <= cfg_data[CAM_EDGE_W-1:0];
				REG_CAM_HIGH_END:       end_q      <= cfg_data[CAM_EDGE_W-1:0];
				REG_MIN_HOLD_CYCLES:    min_hold_q <= cfg_data[MIN_HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign min_hold = min_hold_q;

	// Derived turn and cycle geometry, and classification of the item.
	always_comb begin
		d       = s_axis_tdata;
		ppt_ext = CMP_W'(ppt_q);
		if (ppt_ext == '0) begin
			plen = CMP_W'(1);
		end else if (ppt_ext > MAX_C) begin
			plen = MAX_C;
		end else begin
			plen = ppt_ext;
		end
		absent_ext = CMP_W'(absent_q);
		present    = (absent_ext >= plen) ? '0 : plen - absent_ext;
		total      = plen * TURNS_C;

		start_ext = CMP_W'(start_q);
		end_ext   = CMP_W'(end_q);
		rise      = (start_ext > total) ? total : start_ext;
		fall      = (end_ext > total) ? total : end_ext;
		if (fall < rise) begin
			fall = rise;
		end

		tp_ext   = CMP_W'(tp_q);
		tp_inc   = tp_ext + CMP_W'(1);
		tooth    = tp_ext < present;
		turn_end = tp_inc >= plen;
		gap_acc  = gap_sum_q + d;

		cp_ext     = CMP_W'(cp_q);
		n0         = count_closed(seg_q, rise, fall, total, cp_ext);
		n_all      = count_closed(seg_q, rise, fall, total, cp_ext + CMP_W'(1));
		sum_mid    = (n0 != 2'd0) ? '0 : cam_sum_q;
		sum1       = sum_mid + d;
		seg_end    = seg_q + n_all;
		cycle_done = seg_end == SEG_DONE;
	end

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	always_comb begin
		push_desc.tooth    = tooth;
		push_desc.period   = d;
		push_desc.gap_emit = turn_end;
		push_desc.gap_val  = tooth ? gap_sum_q : gap_acc;
		push_desc.cam_seg  = seg_q;
		push_desc.cam_n0   = n0;
		push_desc.cam_n    = n_all;
		push_desc.cam_sum0 = cam_sum_q;
		push_desc.cam_sum1 = sum1;
	end

	// Position and sum state advances on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tp_q      <= '0;
			cp_q      <= '0;
			gap_sum_q <= '0;
			cam_sum_q <= '0;
			seg_q     <= SEG_LOW_FIRST;
		end else if (push) begin
			if (turn_end) begin
				tp_q      <= '0;
				gap_sum_q <= '0;
			end else begin
				tp_q <= tp_q + TP_W'(1);
				if (!tooth) begin
					gap_sum_q <= gap_acc;
				end
			end
			if (cycle_done) begin
				cp_q      <= '0;
				cam_sum_q <= '0;
				seg_q     <= SEG_LOW_FIRST;
			end else begin
				cp_q      <= cp_q + CP_W'(1);
				cam_sum_q <= (n_all != n0) ? '0 : sum1;
				seg_q     <= seg_end;
			end
		end
	end

endmodule

// File: design/cceg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cceg_queue
// Small descriptor queue that lets classifier and sequencer stall
// independently.
// ----------------------------------------------------------------------------
module cceg_queue import cceg_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cceg_desc_t  push_desc,
	input  logic        pop,
	output logic        head_valid,
	output cceg_desc_t  head_desc,
	output cceg_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cceg_desc_t       entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign qstat.full  = cnt_q == CNT_W'(DEPTH);
	assign qstat.empty = cnt_q == '0;
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head_valid  = !qstat.empty;
	assign head_desc   = entry_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: design/cceg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cceg_back
// Event sequencer. Walks the events of the head descriptor one per cycle
// while the output register is free, subtracts the minimum hold and loads the output register.
// ----------------------------------------------------------------------------
module cceg_back import cceg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  cceg_desc_t            head_desc,
	output logic                  pop,
	input  logic [MIN_HOLD_W-1:0] min_hold,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PERIOD_W-1:0]   m_axis_tdata,
	output logic [2:0]            m_axis_tuser,
	output logic                  m_axis_tlast,
	output cceg_bstat_t           bstat
);

	logic [EVT_CNT_W-1:0] idx_q, n_ev, n_crank;
	logic [1:0]           j, seg;
	logic                 slot_free, skip, fire, is_last;
	logic [PERIOD_W-1:0]  dur, min_ext, half;
	logic                 out_valid_q;
	cceg_event_t          evt, out_q;

	// Event count of the head descriptor.
	always_comb begin
		n_crank = {1'b0, head_desc.tooth, 1'b0} + {2'b00, head_desc.gap_emit};
		n_ev    = n_crank + {1'b0, head_desc.cam_n};
	end

	assign slot_free = !out_valid_q || m_axis_tready;
	assign skip      = head_valid && (n_ev == '0);
	assign fire      = head_valid && (n_ev != '0) && slot_free;
	assign is_last   = idx_q == (n_ev - EVT_CNT_W'(1));
	assign pop       = skip || (fire && is_last);

	// Decode the event at the current index.
	always_comb begin
		half        = head_desc.period >> 1;
		j           = 2'(idx_q - n_crank);
		seg         = head_desc.cam_seg + j;
		evt.channel = CH_CRANK;
		evt.level   = 1'b0;
		dur         = head_desc.gap_val;
		if (idx_q < n_crank) begin
			if (head_desc.tooth && (idx_q == 3'd0)) begin
				evt.level = 1'b1;
				dur       = half;
			end else if (head_desc.tooth && (idx_q == 3'd1)) begin
				dur = head_desc.period - half;
			end
		end else begin
			evt.channel = CH_CAM;
			evt.level   = seg == SEG_HIGH;
			if (j < head_desc.cam_n0) begin
				dur = (j == 2'd0) ? head_desc.cam_sum0 : '0;
			end else begin
				dur = (j == head_desc.cam_n0) ? head_desc.cam_sum1 : '0;
			end
		end
		min_ext       = PERIOD_W'(min_hold);
		evt.underflow = dur < min_ext;
		evt.hold      = evt.underflow ? '0 : dur - min_ext;
		evt.last      = is_last;
	end

	// Event index within the head descriptor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + EVT_CNT_W'(1);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= evt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.hold;
	assign m_axis_tuser  = {out_q.underflow, out_q.level, out_q.channel};
	assign m_axis_tlast  = out_q.last;
	assign bstat.active  = head_valid;
	assign bstat.idx     = idx_q;

endmodule

// File: design/crank_cam_event_generator_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// crank_cam_event_generator_core
// Missing-tooth crank wheel and cam signal event generator.
// ----------------------------------------------------------------------------
// Each input transaction carries the period of one tooth position; the core
// answers with crank and cam events, one output transaction per event, the
// last event of an item flagged by tlast. The classifier takes one input
// transaction per cycle, while the queue is not full, into a two-entry
// descriptor queue; the event sequencer then emits one event per cycle from
// the output register while it is free, so an item with N events (two for an
// ordinary present tooth, up to six at a turn and cycle boundary) holds the
// sequencer until its N events are out. Items that cause no event are retired
// without an output transaction. The output register is what sets the
// sustained rate of one event per cycle; the first event of an item passes
// through a queue entry and then the output register before it is presented.
// ----------------------------------------------------------------------------
module crank_cam_event_generator_core import cceg_pkg::*; #(
	parameter int MAX_POSITIONS_PER_TURN = DEF_MAX_POSITIONS_PER_TURN,
	parameter int TURNS_PER_CYCLE        = DEF_TURNS_PER_CYCLE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// tdata: position_period[31:0]
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PERIOD_W-1:0]   s_axis_tdata,
	// tdata: hold_count[31:0]
	// tuser: channel[0], level[1], underflow[2]
	// tlast: last_of_run
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PERIOD_W-1:0]   m_axis_tdata,
	output logic [2:0]            m_axis_tuser,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                  push, pop, q_full, head_valid;
	cceg_desc_t            push_desc, head_desc;
	cceg_qstat_t           qstat;
	cceg_bstat_t           bstat;
	logic [MIN_HOLD_W-1:0] min_hold;

	assign q_full = qstat.full;

	// Configuration and item classification.
	cceg_front #(
		.MAX_POSITIONS_PER_TURN(MAX_POSITIONS_PER_TURN),
		.TURNS_PER_CYCLE       (TURNS_PER_CYCLE)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.push         (push),
		.push_desc    (push_desc),
		.min_hold     (min_hold)
	);

	// Descriptor queue.
	cceg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head_valid(head_valid),
		.head_desc (head_desc),
		.qstat     (qstat)
	);

	// Event sequencer and output register.
	cceg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_desc    (head_desc),
		.pop          (pop),
		.min_hold     (min_hold),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.bstat        (bstat)
	);

	// Queue bookkeeping is consistent.
	`AST_NEVER(a_queue_full_and_empty, clk, arst_n, qstat.full && qstat.empty)
	// A crank high event is always followed by its low event from the same item.
	`AST_IMPLY(a_crank_high_not_last, clk, arst_n, m_axis_tvalid && (m_axis_tuser[0] == CH_CRANK) && m_axis_tuser[1], !m_axis_tlast)
	// With no descriptor pending, the sequencer sits at the first event.
	`AST_IMPLY(a_idle_index_zero, clk, arst_n, !bstat.active, bstat.idx == '0)
	// The event index never reaches the per-item event limit.
	`AST_NEVER(a_index_in_range, clk, arst_n, bstat.idx >= EVT_IDX_LIMIT)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for crank_cam_event_generator_core. Tooth periods
// are streamed in under several wheel and cam settings, first a short directed
// set of corner cases and then random traffic. A scoreboard predicts the
// crank and cam events of every accepted period and checks each output
// transaction against the oldest pending event.
// ----------------------------------------------------------------------------
module testbench;
	import cceg_pkg::*;

	localparam int          HALF_PERIOD_NS    = 5;
	localparam int          RESET_CYCLES      = 8;
	localparam int          DRAIN_CYCLES      = 16;
	localparam int          LONG_STALL_CYCLES = 300;
	localparam int unsigned LIMIT_CYCLES      = 400000;

	// No register lives at this index; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// ------------------------------------------------------------------------
	// Scoreboard: wheel and cam tracking, expected events, checking.
	// ------------------------------------------------------------------------
	class wheel_event_scoreboard;
		logic [PPT_W-1:0]      positions;
		logic [ABSENT_W-1:0]   absent;
		logic [CAM_EDGE_W-1:0] rise_pos;
		logic [CAM_EDGE_W-1:0] fall_pos;
		logic [MIN_HOLD_W-1:0] min_hold;

		int unsigned           turn_pos;
		int unsigned           cycle_pos;
		int unsigned           cam_range;
		logic [PERIOD_W-1:0]   gap_sum;
		logic [PERIOD_W-1:0]   cam_sum;

		cceg_event_t           expected_events[$];
		cceg_event_t           item_events[$];
		int unsigned           errors;

		function new();
			positions = RST_POSITIONS_PER_TURN;
			absent    = RST_ABSENT_POSITIONS;
			rise_pos  = RST_CAM_HIGH_START;
			fall_pos  = RST_CAM_HIGH_END;
			min_hold  = RST_MIN_HOLD_CYCLES;
			turn_pos  = 0;
			cycle_pos = 0;
			cam_range = 32'(SEG_LOW_FIRST);
			gap_sum   = '0;
			cam_sum   = '0;
			errors    = 0;
		endfunction

		// A register write; each register keeps only its own width.
		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_POSITIONS_PER_TURN: positions = value[PPT_W-1:0];
				REG_ABSENT_POSITIONS:   absent    = value[ABSENT_W-1:0];
				REG_CAM_HIGH_START:     rise_pos  = value[CAM_EDGE_W-1:0];
				REG_CAM_HIGH_END:       fall_pos  = value[CAM_EDGE_W-1:0];
				REG_MIN_HOLD_CYCLES:    min_hold  = value[MIN_HOLD_W-1:0];
				default: ;
			endcase
		endfunction

		function void add_event(logic chan, logic lvl, logic [PERIOD_W-1:0] span);
			cceg_event_t ev;
			ev.channel   = chan;
			ev.level     = lvl;
			ev.underflow = span < PERIOD_W'(min_hold);
			ev.hold      = ev.underflow ? '0 : span - PERIOD_W'(min_hold);
			ev.last      = 1'b0;
			item_events.push_back(ev);
		endfunction

		// Cycle position at which the given cam range closes; edges are clamped
		// to the cycle and a falling edge below the rising one sits on it.
		function int unsigned range_end(int unsigned rng, int unsigned total);
			int unsigned rise;
			int unsigned fall;
			rise = (32'(rise_pos) > total) ? total : 32'(rise_pos);
			fall = (32'(fall_pos) > total) ? total : 32'(fall_pos);
			if (fall < rise)
				fall = rise;
			if (rng == SEG_LOW_FIRST)
				return rise;
			if (rng == SEG_HIGH)
				return fall;
			return total;
		endfunction

		function void close_ranges(int unsigned count, int unsigned total);
			while (cam_range < SEG_DONE && range_end(cam_range, total) <= count) begin
				add_event(CH_CAM, cam_range == SEG_HIGH, cam_sum);
				cam_sum   = '0;
				cam_range = cam_range + 1;
			end
		endfunction

		// An accepted period: advance the wheel and cam, queue its events.
		function void note_period(logic [PERIOD_W-1:0] period);
			int unsigned         plen;
			int unsigned         present;
			int unsigned         total;
			logic [PERIOD_W-1:0] half;
			plen = 32'(positions);
			if (plen == 0)
				plen = 1;
			if (plen > DEF_MAX_POSITIONS_PER_TURN)
				plen = DEF_MAX_POSITIONS_PER_TURN;
			present = (32'(absent) >= plen) ? 0 : plen - 32'(absent);
			total   = plen * DEF_TURNS_PER_CYCLE;
			item_events.delete();

			// Crank: a present tooth is high for half the period, then low;
			// missing positions pile up into the gap closing the turn.
			if (turn_pos < present) begin
				half = period >> 1;
				add_event(CH_CRANK, 1'b1, half);
				add_event(CH_CRANK, 1'b0, period - half);
			end else begin
				gap_sum = gap_sum + period;
			end
			if (turn_pos + 1 >= plen) begin
				add_event(CH_CRANK, 1'b0, gap_sum);
				gap_sum  = '0;
				turn_pos = 0;
			end else begin
				turn_pos = turn_pos + 1;
			end

			// Cam: ranges already passed close before this period counts.
			close_ranges(cycle_pos, total);
			if (cam_range < SEG_DONE)
				cam_sum = cam_sum + period;
			close_ranges(cycle_pos + 1, total);
			if (cam_range >= SEG_DONE) begin
				cam_range = 32'(SEG_LOW_FIRST);
				cam_sum   = '0;
				cycle_pos = 0;
			end else begin
				cycle_pos = cycle_pos + 1;
			end

			if (item_events.size() > 0)
				item_events[item_events.size() - 1].last = 1'b1;
			foreach (item_events[i])
				expected_events.push_back(item_events[i]);
		endfunction

		function void compare_field(string name, logic [PERIOD_W-1:0] want,
				logic [PERIOD_W-1:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		// An accepted output transaction against the oldest expected event.
		function void check_event(logic [PERIOD_W-1:0] data, logic [2:0] user, logic last);
			cceg_event_t want;
			if (expected_events.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual tdata=%h tuser=%b tlast=%b",
					$time, data, user, last);
				errors++;
				return;
			end
			want = expected_events.pop_front();
			compare_field("hold_count", want.hold, data);
			compare_field("channel", PERIOD_W'(want.channel), PERIOD_W'(user[0]));
			compare_field("level", PERIOD_W'(want.level), PERIOD_W'(user[1]));
			compare_field("underflow", PERIOD_W'(want.underflow), PERIOD_W'(user[2]));
			compare_field("last_of_run", PERIOD_W'(want.last), PERIOD_W'(last));
		endfunction

		function int unsigned pending();
			return expected_events.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and the block under test
	// ------------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PERIOD_W-1:0]   s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PERIOD_W-1:0]   m_axis_tdata;
	logic [2:0]            m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	wheel_event_scoreboard sb = new();
	bit                    long_stall_req = 1'b0;
	int unsigned           cycle_count = 0;

	crank_cam_event_generator_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD_NS clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("crank_cam_event_generator_core regression: fail");
			$finish;
		end
	end

	// Every output transaction is checked at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_event(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// Receiver: the stall mode changes at random; on request it
	// holds off for a long stretch so the block backs up into its input.
	initial begin : receiver
		int unsigned mode;
		int unsigned mode_left;
		logic [7:0]  pattern;
		mode      = 0;
		mode_left = 0;
		pattern   = '1;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_STALL_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 80);
				pattern   = 8'($urandom);
			end
			mode_left--;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: begin
					m_axis_tready <= pattern[0];
					pattern = {pattern[0], pattern[7:1]};
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// One input transaction; tvalid stays high for a following period.
	task automatic send_period(input logic [PERIOD_W-1:0] period);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= period;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_period(period);
	endtask

	// One register write transaction; the caller lowers cfg_valid.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, value);
	endtask

	// Wait for every expected event, then for anything still in flight that
	// causes no event.
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] positions,
			input logic [CFG_DATA_W-1:0] absent, input logic [CFG_DATA_W-1:0] rise,
			input logic [CFG_DATA_W-1:0] fall, input logic [CFG_DATA_W-1:0] hold,
			input bit poke_unused);
		settle();
		write_reg(REG_POSITIONS_PER_TURN, positions);
		write_reg(REG_ABSENT_POSITIONS, absent);
		write_reg(REG_CAM_HIGH_START, rise);
		write_reg(REG_CAM_HIGH_END, fall);
		write_reg(REG_MIN_HOLD_CYCLES, hold);
		if (poke_unused)
			write_reg(REG_UNUSED, 9'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Mostly small wheels so turns and cycles complete, now and then the
	// out-of-range and extreme values.
	task automatic configure_random(input bit poke_unused);
		logic [CFG_DATA_W-1:0] positions;
		logic [CFG_DATA_W-1:0] absent;
		logic [CFG_DATA_W-1:0] rise;
		logic [CFG_DATA_W-1:0] fall;
		logic [CFG_DATA_W-1:0] hold;
		int unsigned           plen;
		case ($urandom_range(0, 9))
			0: positions = 9'd0;
			1: positions = 9'd64;
			2: positions = 9'($urandom_range(65, 511));
			default: positions = 9'($urandom_range(1, 8));
		endcase
		plen = 32'(positions[PPT_W-1:0]);
		if (plen == 0)
			plen = 1;
		if (plen > DEF_MAX_POSITIONS_PER_TURN)
			plen = DEF_MAX_POSITIONS_PER_TURN;
		absent = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
			: 9'($urandom_range(0, (plen > 3) ? 3 : plen));
		rise = ($urandom_range(0, 4) == 0) ? 9'($urandom)
			: 9'($urandom_range(0, 2 * plen + 1));
		fall = ($urandom_range(0, 4) == 0) ? 9'($urandom)
			: 9'($urandom_range(0, 2 * plen + 1));
		hold = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 12));
		configure(positions, absent, rise, fall, hold, poke_unused);
	endtask

	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 600);
			4, 5: return $urandom;
			6: return $urandom_range(0, 7);
			7: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			8: return $urandom_range(0, 520);
			default: return $urandom_range(0, 40);
		endcase
	endfunction

	// Random periods sent in bursts with random gaps; optionally the sender
	// pauses halfway until every expected event has come out.
	task automatic run_periods(input int unsigned count, input bit pause_midway);
		int unsigned burst_left;
		burst_left = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				if ($urandom_range(0, 3) != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end
			end
			send_period(pick_period());
			burst_left--;
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [PERIOD_W-1:0] reset_periods [7];
		logic [PERIOD_W-1:0] wrap_periods  [7];
		reset_periods = '{32'd0, 32'd1, 32'd5, 32'd6, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF};
		wrap_periods  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd255, 32'd254};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: period extremes and the minimum hold boundary.
		foreach (reset_periods[i])
			send_period(reset_periods[i]);
		s_axis_tvalid <= 1'b0;

		// Zero turn length acts as one; both cam edges at position zero, so
		// empty ranges close at the first item of the cycle.
		configure(9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 1'b0);
		for (int i = 0; i < 4; i++)
			send_period(32'd7 + i);
		s_axis_tvalid <= 1'b0;

		// Cam edges beyond the cycle, falling edge below rising, largest
		// minimum hold, and gap and cam sums that wrap.
		configure(9'd4, 9'd3, 9'h1FF, 9'd5, 9'd255, 1'b0);
		foreach (wrap_periods[i])
			send_period(wrap_periods[i]);
		s_axis_tvalid <= 1'b0;

		// Turn length beyond the maximum, most absent positions, edges at the
		// cycle end, and a write to an index with no register.
		configure(9'h1FF, 9'd63, 9'd256, 9'd256, 9'd128, 1'b1);
		for (int i = 0; i < 3; i++)
			send_period(32'd300 - i);
		s_axis_tvalid <= 1'b0;

		// Every position missing: each turn yields only its gap event on the crank channel.
		configure(9'd2, 9'd2, 9'd1, 9'd3, 9'd1, 1'b0);
		for (int i = 0; i < 4; i++)
			send_period(32'd1 << (i * 8));
		s_axis_tvalid <= 1'b0;

		// Random phases; one starts under a long receiver hold-off, another
		// pauses the sender until everything has come out.
		for (int phase = 0; phase < 6; phase++) begin
			configure_random(phase == 3);
			if (phase == 1)
				long_stall_req = 1'b1;
			run_periods($urandom_range(24, 36), phase == 4);
		end

		// A full-size wheel long enough to finish a turn.
		configure(9'd64, 9'($urandom_range(0, 4)), 9'($urandom_range(0, 128)),
			9'($urandom_range(0, 128)), 9'($urandom_range(0, 8)), 1'b0);
		run_periods(66, 1'b0);

		settle();
		if (sb.errors == 0)
			$display("crank_cam_event_generator_core regression: pass");
		else
			$display("crank_cam_event_generator_core regression: fail");
		$finish;
	end

endmodule

// File: crank_cam_event_generator_core.f
+incdir+design
design/cceg_pkg.sv
design/cceg_front.sv
design/cceg_queue.sv
design/cceg_back.sv
design/crank_cam_event_generator_core.sv
tb/testbench.sv
